@@ design/clws_pkg.sv @@
`default_nettype none

package clws_pkg;

  // request kinds carried on in_tuser
  localparam logic [2:0] MODE_COMMAND = 3'd0;
  localparam logic [2:0] MODE_CHAR    = 3'd1;
  localparam logic [2:0] MODE_POS     = 3'd2;
  localparam logic [2:0] MODE_HOME    = 3'd3;
  localparam logic [2:0] MODE_CLEAR   = 3'd4;
  localparam logic [2:0] MODE_FLAG    = 3'd5;
  localparam logic [2:0] MODE_NIBBLE  = 3'd6;

  // control flag selectors
  localparam logic [1:0] FLAG_BLINK   = 2'd0;
  localparam logic [1:0] FLAG_CURSOR  = 2'd1;
  localparam logic [1:0] FLAG_DISPLAY = 2'd2;

  // display command bytes
  localparam logic [7:0] CMD_CLEAR   = 8'h01;
  localparam logic [7:0] CMD_HOME    = 8'h02;
  localparam logic [7:0] CMD_CTRL    = 8'h08;
  localparam logic [7:0] CMD_DDRAM   = 8'h80;
  localparam logic [7:0] ROW_OFFSET  = 8'h40;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_FOUR_BIT  = 2'd0;
  localparam logic [1:0] REG_COL_COUNT = 2'd1;
  localparam logic [1:0] REG_ROW_COUNT = 2'd2;

  // queue depth
  localparam int unsigned QDEPTH = 2;

  // one classified request, as handed from front to back
  typedef struct packed {
    logic       nib_only;   // single low-nibble strobe
    logic       four_bit;   // bus width snapshot
    logic       two_bytes;  // second command byte follows
    logic       rs0;        // register select of first byte
    logic [7:0] byte0;
    logic [7:0] byte1;      // always sent as a command
  } entry_t;

endpackage

`default_nettype wire

@@ design/char_lcd_write_sequencer.sv @@
// Character-LCD write sequencer.
// in_* : request words. in_tuser carries the request kind; in_tdata the byte,
//        target column/row and control-flag fields. A word is taken when
//        in_tvalid and in_tready are both high.
// out_*: one word per enable strobe: out_tdata the pin levels, out_tuser the
//        register-select level, out_tlast marks the final strobe of a request.
// cfg_*: register port for bus width, column count and row count; the user
//        must write it only while the block is idle; the block does not enforce it.
// A request passes the queue, the current-request and the output registers.
// Throughput: one strobe per cycle while the receiver is ready; a request
//        gives 1 to 4 strobes (a wrapping character write or a clear on a 4-bit
//        bus gives the most, 4); the output stage sets this rate.
// A two-entry queue between the classifier and the strobe generator lets new
// requests be taken while earlier strobes are still going out. When the
// receiver stalls, the output word holds, the queue fills and in_tready drops.
// Reset clears the cursor, the control flags, the queue and the output, and
// loads the register defaults (4-bit bus, 16 columns, 2 rows).
`default_nettype none

module char_lcd_write_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // byte_value[7:0], col_x[13:8], row_y[16:14],
                                      // flag_select[18:17], flag_value[19], zero[23:20]
  input  wire logic [2:0]  in_tuser,  // mode[2:0]
  // strobe channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // bus_data[7:0]
  output logic             out_tuser, // reg_select[0]
  output logic             out_tlast,
  // register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic             four_bit_r;
  logic [5:0]       column_count_r;
  logic [2:0]       row_count_r;
  logic             cfg_wr;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [1:0]       q_count;
  clws_pkg::entry_t push_entry;
  clws_pkg::entry_t pop_entry;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_bit_r     <= 1'b1;
      column_count_r <= 6'd16;
      row_count_r    <= 3'd2;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        clws_pkg::REG_FOUR_BIT:  four_bit_r     <= cfg_pwdata[0];
        clws_pkg::REG_COL_COUNT: column_count_r <= cfg_pwdata[5:0];
        clws_pkg::REG_ROW_COUNT: row_count_r    <= cfg_pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      clws_pkg::REG_FOUR_BIT:  cfg_prdata = {31'd0, four_bit_r};
      clws_pkg::REG_COL_COUNT: cfg_prdata = {26'd0, column_count_r};
      clws_pkg::REG_ROW_COUNT: cfg_prdata = {29'd0, row_count_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // classifier
  clws_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .four_bit     (four_bit_r),
    .column_count (column_count_r),
    .row_count    (row_count_r),
    .q_full       (q_full),
    .push         (q_push),
    .entry        (push_entry)
  );

  // request queue
  clws_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .full       (q_full),
    .empty      (q_empty),
    .count      (q_count)
  );

  // strobe generator
  clws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_entry    (pop_entry),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("queue push while full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= 2'(clws_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_col_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && cfg_paddr[3:2] == clws_pkg::REG_COL_COUNT |=>
      column_count_r == $past(cfg_pwdata[5:0]))
    else $error("column count write lost");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("strobe shown right after reset");

endmodule

`default_nettype wire

@@ design/clws_front.sv @@
`default_nettype none

module clws_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [23:0]       in_tdata,
  input  wire logic [2:0]        in_tuser,
  input  wire logic              four_bit,
  input  wire logic [5:0]        column_count,
  input  wire logic [2:0]        row_count,
  input  wire logic              q_full,
  output logic                   push,
  output clws_pkg::entry_t       entry
);

  logic [5:0] cursor_col_r, cursor_col_nxt;
  logic [2:0] cursor_row_r, cursor_row_nxt;
  logic [2:0] flags_r, flags_nxt;

  logic [7:0] byte_value;
  logic [5:0] col_x;
  logic [2:0] row_y;
  logic [1:0] flag_select;
  logic       flag_value;
  logic       accept;
  logic       has_result;
  logic [5:0] col_inc;
  logic [2:0] row_inc;
  logic [2:0] row_wrap;
  logic [2:0] flag_bit;
  logic [7:0] pos_base;

  // unpack the word
  assign byte_value  = in_tdata[7:0];
  assign col_x       = in_tdata[13:8];
  assign row_y       = in_tdata[16:14];
  assign flag_select = in_tdata[18:17];
  assign flag_value  = in_tdata[19];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && has_result;

  assign col_inc  = cursor_col_r + 6'd1;
  assign row_inc  = cursor_row_r + 3'd1;
  assign row_wrap = (row_inc == row_count) ? 3'd0 : row_inc;
  assign flag_bit = 3'(3'd1 << flag_select);
  assign pos_base = clws_pkg::CMD_DDRAM | ((row_y != 3'd0) ? clws_pkg::ROW_OFFSET : 8'h00);

  // classify the request and work out the cursor and flag updates
  always_comb begin
    cursor_col_nxt   = cursor_col_r;
    cursor_row_nxt   = cursor_row_r;
    flags_nxt        = flags_r;
    has_result       = 1'b0;
    entry.nib_only   = 1'b0;
    entry.four_bit   = four_bit;
    entry.two_bytes  = 1'b0;
    entry.rs0        = 1'b0;
    entry.byte0      = byte_value;
    entry.byte1      = clws_pkg::CMD_HOME;
    case (in_tuser)
      clws_pkg::MODE_COMMAND: begin
        has_result = 1'b1;
      end
      clws_pkg::MODE_CHAR: begin
        has_result = 1'b1;
        entry.rs0  = 1'b1;
        if (col_inc == column_count) begin
          cursor_col_nxt  = 6'd0;
          cursor_row_nxt  = row_wrap;
          entry.two_bytes = 1'b1;
          entry.byte1     = clws_pkg::CMD_DDRAM |
                            ((row_wrap != 3'd0) ? clws_pkg::ROW_OFFSET : 8'h00);
        end else begin
          cursor_col_nxt = col_inc;
        end
      end
      clws_pkg::MODE_POS: begin
        if (!(col_x > column_count || row_y > row_count)) begin
          has_result     = 1'b1;
          entry.byte0    = pos_base + {2'b00, col_x};
          cursor_col_nxt = col_x;
          cursor_row_nxt = row_y;
        end
      end
      clws_pkg::MODE_HOME: begin
        has_result     = 1'b1;
        entry.byte0    = clws_pkg::CMD_HOME;
        cursor_col_nxt = 6'd0;
        cursor_row_nxt = 3'd0;
      end
      clws_pkg::MODE_CLEAR: begin
        has_result      = 1'b1;
        entry.byte0     = clws_pkg::CMD_CLEAR;
        entry.two_bytes = 1'b1;
        entry.byte1     = clws_pkg::CMD_HOME;
        cursor_col_nxt  = 6'd0;
        cursor_row_nxt  = 3'd0;
      end
      clws_pkg::MODE_FLAG: begin
        if (flag_select inside {clws_pkg::FLAG_BLINK, clws_pkg::FLAG_CURSOR,
                                clws_pkg::FLAG_DISPLAY}) begin
          has_result  = 1'b1;
          flags_nxt   = flag_value ? (flags_r | flag_bit) : (flags_r & ~flag_bit);
          entry.byte0 = clws_pkg::CMD_CTRL | {5'b00000, flags_nxt};
        end
      end
      clws_pkg::MODE_NIBBLE: begin
        has_result     = 1'b1;
        entry.nib_only = 1'b1;
        entry.byte0    = byte_value & clws_pkg::NIBBLE_MASK;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // cursor and flag state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_col_r <= 6'd0;
      cursor_row_r <= 3'd0;
      flags_r      <= 3'd0;
    end else if (accept) begin
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      flags_r      <= flags_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/clws_queue.sv @@
`default_nettype none

module clws_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire clws_pkg::entry_t  push_entry,
  input  wire logic              pop,
  output clws_pkg::entry_t       pop_entry,
  output logic                   full,
  output logic                   empty,
  output logic [1:0]             count
);

  clws_pkg::entry_t slot_r [clws_pkg::QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full      = (count_r == 2'(clws_pkg::QDEPTH));
  assign empty     = (count_r == 2'd0);
  assign count     = count_r;
  assign pop_entry = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

@@ design/clws_back.sv @@
`default_nettype none

module clws_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire clws_pkg::entry_t  q_entry,
  input  wire logic              q_empty,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  clws_pkg::entry_t cur_r, cur_nxt;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_rs_r;
  logic       out_last_r;

  logic       advance;
  logic       load_cur;
  logic [1:0] last_idx;
  logic       is_last;
  logic       sel_second;
  logic [7:0] sel_byte;
  logic       sel_rs;
  logic [7:0] strobe_data;

  // index of the final strobe of the current request
  always_comb begin
    if (cur_r.nib_only) begin
      last_idx = 2'd0;
    end else if (cur_r.two_bytes) begin
      last_idx = cur_r.four_bit ? 2'd3 : 2'd1;
    end else begin
      last_idx = cur_r.four_bit ? 2'd1 : 2'd0;
    end
  end

  assign is_last  = (idx_r == last_idx);
  assign advance  = cur_valid_r && (!out_valid_r || out_tready);
  assign load_cur = !cur_valid_r || (advance && is_last);
  assign q_pop    = load_cur && !q_empty;

  // pick the byte and nibble for this strobe
  assign sel_second = cur_r.four_bit ? idx_r[1] : idx_r[0];
  assign sel_byte   = sel_second ? cur_r.byte1 : cur_r.byte0;
  assign sel_rs     = sel_second ? 1'b0 : cur_r.rs0;

  always_comb begin
    if (cur_r.nib_only) begin
      strobe_data = cur_r.byte0 & clws_pkg::NIBBLE_MASK;
    end else if (cur_r.four_bit) begin
      strobe_data = idx_r[0] ? {4'h0, sel_byte[3:0]} : {4'h0, sel_byte[7:4]};
    end else begin
      strobe_data = sel_byte;
    end
  end

  // current request and strobe index
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load_cur) begin
      cur_nxt       = q_entry;
      cur_valid_nxt = !q_empty;
      idx_nxt       = 2'd0;
    end else if (advance) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= strobe_data;
      out_rs_r   <= sel_rs;
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_rs_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ sim/lcd_strobe_checker.sv @@
module lcd_strobe_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,  // byte_value, col_x, row_y, flag_select, flag_value
  input  wire logic [2:0]  in_tuser,  // mode
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata, // bus_data
  input  wire logic        out_tuser, // reg_select
  input  wire logic        out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  input  wire logic        cfg_pready,
  input  wire logic        end_check,
  output int               pending,
  output int               fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       reg_sel;
    logic [7:0] bus_data;
    logic       last;
  } strobe_t;

  // register copies
  logic       nibble_bus;
  logic [5:0] col_count;
  logic [2:0] row_count;

  // display state
  logic [5:0] cursor_col;
  logic [2:0] cursor_row;
  logic [2:0] ctrl_flags;

  strobe_t strobe_q[$];
  strobe_t new_strobes[4];
  int      new_count;
  int      mismatches = 0;
  int      queued = 0;

  assign fail_count = mismatches;
  assign pending    = queued;

  task automatic report_mismatch(input string what);
    if (mismatches < 40) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [7:0] ddram_addr(input logic [5:0] col, input logic [2:0] row);
    return {2'b00, col} +
           (clws_pkg::CMD_DDRAM | ((row != 3'd0) ? clws_pkg::ROW_OFFSET : 8'h00));
  endfunction

  task automatic add_strobe(input logic rs, input logic [7:0] data);
    new_strobes[new_count] = '{reg_sel: rs, bus_data: data, last: 1'b0};
    new_count++;
  endtask

  // a byte goes out as high then low nibble on the narrow bus
  task automatic add_byte(input logic rs, input logic [7:0] value);
    if (nibble_bus) begin
      add_strobe(rs, {4'h0, value[7:4]});
      add_strobe(rs, {4'h0, value[3:0]});
    end else begin
      add_strobe(rs, value);
    end
  endtask

  // work out the strobes of one request and move the cursor and flags
  task automatic predict_strobes(input logic [2:0] mode, input logic [23:0] word);
    logic [7:0] value;
    logic [5:0] col_x;
    logic [2:0] row_y;
    logic [1:0] fsel;
    logic       fval;
    logic [2:0] flag_bit;
    value    = word[7:0];
    col_x    = word[13:8];
    row_y    = word[16:14];
    fsel     = word[18:17];
    fval     = word[19];
    new_count = 0;
    case (mode)
      clws_pkg::MODE_COMMAND: add_byte(1'b0, value);
      clws_pkg::MODE_CHAR: begin
        add_byte(1'b1, value);
        cursor_col = cursor_col + 6'd1;
        if (cursor_col == col_count) begin
          cursor_col = '0;
          cursor_row = cursor_row + 3'd1;
          if (cursor_row == row_count) cursor_row = '0;
          add_byte(1'b0, ddram_addr(cursor_col, cursor_row));
        end
      end
      clws_pkg::MODE_POS: begin
        if (col_x <= col_count && row_y <= row_count) begin
          add_byte(1'b0, ddram_addr(col_x, row_y));
          cursor_col = col_x;
          cursor_row = row_y;
        end
      end
      clws_pkg::MODE_HOME: begin
        add_byte(1'b0, clws_pkg::CMD_HOME);
        cursor_col = '0;
        cursor_row = '0;
      end
      clws_pkg::MODE_CLEAR: begin
        add_byte(1'b0, clws_pkg::CMD_CLEAR);
        add_byte(1'b0, clws_pkg::CMD_HOME);
        cursor_col = '0;
        cursor_row = '0;
      end
      clws_pkg::MODE_FLAG: begin
        if (fsel <= clws_pkg::FLAG_DISPLAY) begin
          flag_bit   = 3'b001 << fsel;
          ctrl_flags = fval ? (ctrl_flags | flag_bit) : (ctrl_flags & ~flag_bit);
          add_byte(1'b0, clws_pkg::CMD_CTRL | {5'b0, ctrl_flags});
        end
      end
      clws_pkg::MODE_NIBBLE: add_strobe(1'b0, value & clws_pkg::NIBBLE_MASK);
      default: ;
    endcase
    for (int i = 0; i < new_count; i++) begin
      if (i == new_count - 1) new_strobes[i].last = 1'b1;
      strobe_q.push_back(new_strobes[i]);
    end
  endtask

  // compare one strobe word with the oldest expectation
  task automatic check_strobe();
    strobe_t want;
    if (strobe_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word rs=%0b data=%02h last=%0b",
                                out_tuser, out_tdata, out_tlast));
      return;
    end
    want = strobe_q.pop_front();
    if (out_tuser !== want.reg_sel)
      report_mismatch($sformatf("reg_select %0b, want %0b", out_tuser, want.reg_sel));
    if (out_tdata !== want.bus_data)
      report_mismatch($sformatf("bus_data %02h, want %02h", out_tdata, want.bus_data));
    if (out_tlast !== want.last)
      report_mismatch($sformatf("last %0b, want %0b", out_tlast, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      nibble_bus = 1'b1;
      col_count  = 6'd16;
      row_count  = 3'd2;
      cursor_col = '0;
      cursor_row = '0;
      ctrl_flags = '0;
      strobe_q.delete();
    end else begin
      if (in_tvalid && in_tready) predict_strobes(in_tuser, in_tdata);
      if (out_tvalid && out_tready) check_strobe();
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          clws_pkg::REG_FOUR_BIT:  nibble_bus = cfg_pwdata[0];
          clws_pkg::REG_COL_COUNT: col_count  = cfg_pwdata[5:0];
          clws_pkg::REG_ROW_COUNT: row_count  = cfg_pwdata[2:0];
          default: ;
        endcase
      end
      if (end_check && strobe_q.size() != 0)
        report_mismatch($sformatf("%0d words never arrived", strobe_q.size()));
    end
    queued = strobe_q.size();
  end

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // request kinds and selectors outside the package's range
  localparam logic [2:0] MODE_UNUSED = 3'd7;
  localparam logic [1:0] FLAG_NONE   = 2'd3;

  typedef enum int {RX_FREE, RX_CHOPPY, RX_HELD} rx_style_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;  // byte_value, col_x, row_y, flag_select, flag_value
  logic [2:0]  in_tuser    = '0;  // mode
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;         // bus_data
  logic        out_tuser;         // reg_select
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        end_check   = 1'b0;
  int          pending;
  int          fail_count;

  // sender burst state and the limits the block is set to
  int          burst_left  = 4;
  int          col_limit   = 16;
  int          row_limit   = 2;
  rx_style_t   rx_style    = RX_FREE;
  int          rx_left     = 0;

  char_lcd_write_sequencer dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  lcd_strobe_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .end_check, .pending, .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: free-running, choppy and held stretches
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 2));
      rx_left  = (rx_style == RX_HELD) ? $urandom_range(1, 6) : $urandom_range(4, 30);
    end
    rx_left--;
    case (rx_style)
      RX_FREE:   out_tready <= 1'b1;
      RX_CHOPPY: out_tready <= 1'($urandom_range(0, 1));
      default:   out_tready <= 1'b0;
    endcase
  end

  function automatic logic [23:0] pack_request(input logic [7:0] value, input logic [5:0] col,
                                               input logic [2:0] row, input logic [1:0] fsel,
                                               input logic fval);
    return {4'h0, fval, fsel, row, col, value};
  endfunction

  // one request word, then sometimes a gap when the burst runs out
  task automatic send_request(input logic [2:0] mode, input logic [23:0] word);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    if (in_tvalid) in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    // ignored requests may still be in the pipe
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic reconfigure(input logic four_bit, input int cols, input int rows);
    wait_drained();
    write_reg(clws_pkg::REG_FOUR_BIT, {31'b0, four_bit});
    write_reg(clws_pkg::REG_COL_COUNT, 32'(cols));
    write_reg(clws_pkg::REG_ROW_COUNT, 32'(rows));
    col_limit = cols;
    row_limit = rows;
    @(posedge clk);
  endtask

  // random requests, mostly characters and in-range positions
  task automatic random_requests(input int count);
    int         done;
    int         pick;
    logic [2:0] mode;
    logic [7:0] value;
    logic [5:0] col;
    logic [2:0] row;
    logic [1:0] fsel;
    logic       fval;
    logic       ignored;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      mode = clws_pkg::MODE_CHAR;
      else if (pick < 55) mode = clws_pkg::MODE_POS;
      else if (pick < 65) mode = clws_pkg::MODE_COMMAND;
      else if (pick < 75) mode = clws_pkg::MODE_FLAG;
      else if (pick < 83) mode = clws_pkg::MODE_NIBBLE;
      else if (pick < 89) mode = clws_pkg::MODE_HOME;
      else if (pick < 95) mode = clws_pkg::MODE_CLEAR;
      else                mode = MODE_UNUSED;
      value = 8'($urandom_range(0, 255));
      col   = 6'(($urandom_range(0, 3) != 0) ? $urandom_range(0, col_limit)
                                             : $urandom_range(0, 63));
      row   = 3'(($urandom_range(0, 3) != 0) ? $urandom_range(0, row_limit)
                                             : $urandom_range(0, 7));
      fsel  = 2'($urandom_range(0, 3));
      fval  = 1'($urandom_range(0, 1));
      ignored = (mode == MODE_UNUSED) ||
                (mode == clws_pkg::MODE_FLAG && fsel == FLAG_NONE) ||
                (mode == clws_pkg::MODE_POS && (col > col_limit || row > row_limit));
      send_request(mode, pack_request(value, col, row, fsel, fval));
      if (!ignored) done++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, wraps, ignored cases, every request kind
    send_request(clws_pkg::MODE_COMMAND,
                 pack_request(8'h00, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_COMMAND,
                 pack_request(8'hFF, 6'd63, 3'd7, FLAG_NONE, 1'b1));
    send_request(clws_pkg::MODE_CHAR,
                 pack_request(8'h00, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_CHAR,
                 pack_request(8'hFF, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_POS,
                 pack_request(8'h00, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    // equality with the counts is accepted
    send_request(clws_pkg::MODE_POS,
                 pack_request(8'h00, 6'd16, 3'd2, clws_pkg::FLAG_BLINK, 1'b0));
    // out of range positions are dropped
    send_request(clws_pkg::MODE_POS,
                 pack_request(8'h00, 6'd17, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_POS,
                 pack_request(8'h00, 6'd0, 3'd3, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_POS,
                 pack_request(8'hFF, 6'd63, 3'd7, FLAG_NONE, 1'b1));
    // wrap from the last row back to row 0, then from row 0 to row 1
    send_request(clws_pkg::MODE_POS,
                 pack_request(8'h00, 6'd15, 3'd1, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_CHAR,
                 pack_request(8'h41, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_POS,
                 pack_request(8'h00, 6'd15, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_CHAR,
                 pack_request(8'h42, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    // cursor past the wrap point does not wrap
    send_request(clws_pkg::MODE_POS,
                 pack_request(8'h00, 6'd16, 3'd1, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_CHAR,
                 pack_request(8'h43, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_HOME,
                 pack_request(8'h00, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_CLEAR,
                 pack_request(8'h00, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_FLAG,
                 pack_request(8'h00, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b1));
    send_request(clws_pkg::MODE_FLAG,
                 pack_request(8'h00, 6'd0, 3'd0, clws_pkg::FLAG_CURSOR, 1'b1));
    send_request(clws_pkg::MODE_FLAG,
                 pack_request(8'h00, 6'd0, 3'd0, clws_pkg::FLAG_DISPLAY, 1'b1));
    send_request(clws_pkg::MODE_FLAG,
                 pack_request(8'h00, 6'd0, 3'd0, clws_pkg::FLAG_DISPLAY, 1'b0));
    send_request(clws_pkg::MODE_FLAG,
                 pack_request(8'h00, 6'd0, 3'd0, FLAG_NONE, 1'b1));
    send_request(clws_pkg::MODE_NIBBLE,
                 pack_request(8'hAB, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(clws_pkg::MODE_NIBBLE,
                 pack_request(8'hF0, 6'd0, 3'd0, clws_pkg::FLAG_BLINK, 1'b0));
    send_request(MODE_UNUSED, pack_request(8'hFF, 6'd63, 3'd7, FLAG_NONE, 1'b1));

    // random phases over several register settings
    random_requests(52);
    reconfigure(1'b0, 1, 1);
    random_requests(52);
    reconfigure(1'b1, 40, 4);
    random_requests(52);
    reconfigure(1'b0, 40, 1);
    random_requests(52);
    reconfigure(1'b1, 1, 4);
    random_requests(52);
    reconfigure(1'b1, 7, 3);
    random_requests(52);
    reconfigure(1'b0, 31, 2);
    random_requests(52);
    // zero and oversized counts
    reconfigure(1'b1, 0, 0);
    random_requests(40);
    reconfigure(1'b0, 63, 7);
    random_requests(40);

    wait_drained();
    repeat (10) @(posedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
